[hdl/fctl_pkg.sv]
// fctl_pkg: shared types, constants and helpers of the cache tag lookup block.
// Used by fctl_ctrl, fctl_datapath and fifo_cache_tag_lookup. No dependencies.
package fctl_pkg;

   localparam int ADDR_BITS      = 32;
   localparam int LINE_BYTES     = 64;
   localparam int MAX_LINES      = 64;
   localparam int BANKS          = 2;
   localparam int OFFSET_W       = $clog2(LINE_BYTES);
   localparam int INDEX_W        = $clog2(MAX_LINES);
   localparam int BLOCK_W        = ADDR_BITS - OFFSET_W;
   localparam int TAG_W          = BLOCK_W;
   localparam int ENTRY_W        = $clog2(BANKS * MAX_LINES);
   localparam int COUNT_W        = 64;
   localparam int LOG2_W         = 3;

   // configuration port
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT_MODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINES_LOG2 = 2'd2;

   localparam logic [LOG2_W-1:0] LINES_LOG2_RESET = 3'd6;

   typedef struct packed {
      logic [ADDR_BITS-1:0] address;
      logic                 is_data;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [COUNT_W-1:0] access_count;
      logic [COUNT_W-1:0] hit_count;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic compare;
      logic update;
      logic cfg_we;
   } cmd_type;

   // clamp the line count exponent to 1..INDEX_W
   function automatic logic [LOG2_W-1:0] clamp_log2(input logic [LOG2_W-1:0] lg);
      logic [LOG2_W-1:0] r;
      r = lg;
      if (r < LOG2_W'(1)) r = LOG2_W'(1);
      if (r > LOG2_W'(INDEX_W)) r = LOG2_W'(INDEX_W);
      return r;
   endfunction

endpackage

[hdl/fctl_ctrl.sv]
// fctl_ctrl: sequencer of the tag lookup (compare cycle, update cycle).
// Depends on fctl_pkg.
module fctl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              csr_valid,
   output logic              busy,
   output logic              csr_ready,
   output logic              rsp_valid,
   output fctl_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CMP  = 2'd1;
   localparam logic [1:0] ST_UPD  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff;
   logic       accept;

   assign busy      = (state_ff == ST_CMP);
   assign csr_ready = (state_ff == ST_IDLE);
   assign accept    = start & ~busy;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: state_in = accept ? ST_CMP : ST_IDLE;
         ST_CMP:  state_in = ST_UPD;
         ST_UPD:  state_in = accept ? ST_CMP : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.load_req = accept;
      cmd.compare  = (state_ff == ST_CMP);
      cmd.update   = (state_ff == ST_UPD);
      cmd.cfg_we   = csr_valid & csr_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_UPD);
      end
   end

endmodule

[hdl/fctl_datapath.sv]
// fctl_datapath: config registers, tag/valid line array with per-line comparators,
// victim select, fill pointers and counters. Depends on fctl_pkg.
module fctl_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fctl_pkg::cmd_type                    cmd,
   input  fctl_pkg::req_type                    req_data,
   input  logic [fctl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fctl_pkg::CSR_DATA_W-1:0]      csr_data,
   output fctl_pkg::rsp_type                    rsp_data
);

   localparam int ML = fctl_pkg::MAX_LINES;
   localparam int IW = fctl_pkg::INDEX_W;
   localparam int TW = fctl_pkg::TAG_W;

   // configuration
   logic                          map_mode_ff;
   logic                          split_mode_ff;
   logic [fctl_pkg::LOG2_W-1:0]   lines_log2_ff;

   // request and line store
   fctl_pkg::req_type             req_ff;
   logic [2*ML-1:0]               valid_ff;
   logic [TW-1:0]                 tag_ff [2*ML];
   logic [IW-1:0]                 fptr_ff [fctl_pkg::BANKS];
   logic [fctl_pkg::COUNT_W-1:0]  acc_ff, acc_in;
   logic [fctl_pkg::COUNT_W-1:0]  hits_ff, hits_in;
   fctl_pkg::rsp_type             rsp_ff;

   // compare stage
   logic                          bank;
   logic [fctl_pkg::LOG2_W-1:0]   lg;
   logic [IW-1:0]                 lmask;
   logic [fctl_pkg::BLOCK_W-1:0]  block;
   logic [IW-1:0]                 idx;
   logic [TW-1:0]                 cmp_tag;
   logic [ML-1:0]                 match_in, free_in;
   logic [ML-1:0]                 match_ff, free_ff;
   logic [TW-1:0]                 cmp_tag_ff;
   logic [IW-1:0]                 idx_ff, lmask_ff;
   logic                          bank_ff;

   // update stage
   logic                          hit;
   logic [IW-1:0]                 first_free;
   logic [IW-1:0]                 victim;
   logic [IW-1:0]                 fptr_in;
   logic [fctl_pkg::ENTRY_W-1:0]  wr_entry;

   assign lg      = fctl_pkg::clamp_log2(lines_log2_ff);
   assign lmask   = {IW{1'b1}} >> (fctl_pkg::LOG2_W'(IW) - lg);
   assign bank    = split_mode_ff & req_ff.is_data;
   assign block   = req_ff.address[fctl_pkg::ADDR_BITS-1:fctl_pkg::OFFSET_W];
   assign idx     = block[IW-1:0] & lmask;
   assign cmp_tag = map_mode_ff ? block : (block >> lg);

   // one comparator per line of the selected bank
   always_comb begin
      for (int i = 0; i < ML; i++) begin
         logic [TW-1:0] lane_tag;
         logic          lane_valid;
         logic          in_use;
         logic          sel;
         lane_tag   = bank ? tag_ff[ML+i] : tag_ff[i];
         lane_valid = bank ? valid_ff[ML+i] : valid_ff[i];
         in_use     = ((IW'(i) & ~lmask) == '0);
         sel        = map_mode_ff ? in_use : (IW'(i) == idx);
         match_in[i] = sel & lane_valid & (lane_tag == cmp_tag);
         free_in[i]  = in_use & ~lane_valid;
      end
   end

   // lowest free line
   always_comb begin
      first_free = '0;
      for (int i = ML - 1; i >= 0; i--) begin
         if (free_ff[i]) first_free = IW'(i);
      end
   end

   assign hit      = |match_ff;
   assign victim   = !map_mode_ff ? idx_ff :
                     (|free_ff) ? first_free : (fptr_ff[bank_ff] & lmask_ff);
   assign fptr_in  = (victim + IW'(1)) & lmask_ff;
   assign wr_entry = {bank_ff, victim};
   assign acc_in   = acc_ff + fctl_pkg::COUNT_W'(1);
   assign hits_in  = hits_ff + fctl_pkg::COUNT_W'(hit);

   always_ff @(posedge clock) begin
      if (reset) begin
         map_mode_ff   <= 1'b0;
         split_mode_ff <= 1'b0;
         lines_log2_ff <= fctl_pkg::LINES_LOG2_RESET;
         valid_ff      <= '0;
         fptr_ff[0]    <= '0;
         fptr_ff[1]    <= '0;
         acc_ff        <= '0;
         hits_ff       <= '0;
      end else begin
         if (cmd.cfg_we) begin
            unique case (csr_index)
               fctl_pkg::CSR_MAP_MODE:   map_mode_ff   <= csr_data[0];
               fctl_pkg::CSR_SPLIT_MODE: split_mode_ff <= csr_data[0];
               fctl_pkg::CSR_LINES_LOG2: lines_log2_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.update) begin
            acc_ff  <= acc_in;
            hits_ff <= hits_in;
            if (!hit) begin
               valid_ff[wr_entry] <= 1'b1;
               if (map_mode_ff) fptr_ff[bank_ff] <= fptr_in;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_data;
      if (cmd.compare) begin
         match_ff   <= match_in;
         free_ff    <= free_in;
         cmp_tag_ff <= cmp_tag;
         idx_ff     <= idx;
         lmask_ff   <= lmask;
         bank_ff    <= bank;
      end
      if (cmd.update) begin
         if (!hit) tag_ff[wr_entry] <= cmp_tag_ff;
         rsp_ff.hit          <= hit;
         rsp_ff.access_count <= acc_in;
         rsp_ff.hit_count    <= hits_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

[hdl/fifo_cache_tag_lookup.sv]
// fifo_cache_tag_lookup: top level of the cache tag lookup block.
// Depends on fctl_pkg, fctl_ctrl and fctl_datapath.
//
// Cache tag store, one access word at a time. A word (address, is_data) is
// taken at a clock edge where start is high and busy is low. busy is high for
// exactly one cycle after each accept, so a new word can already be taken
// during the update of the last one. Each word passes the tag compare (all
// lines of a bank compared at once, hit and free vectors registered), then
// the update (hit reduce, victim pick, tag write, counter add), which also
// registers the result word, shown on rsp_data for one cycle with
// rsp_valid; there is no backpressure, so the receiver must take it then.
// Lines are 64 bytes, 2..64 lines per bank, unified or split I/D banks,
// direct-mapped or fully associative with round-robin (FIFO) replacement.
// Config registers (csr_index 0 map_mode, 1 split_mode, 2 lines_log2) are
// written only when the block is idle; csr_ready is high only then. Reset
// clears all valid bits, fill pointers and counters.
module fifo_cache_tag_lookup (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  fctl_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   output fctl_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fctl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fctl_pkg::CSR_DATA_W-1:0]      csr_data
);

   fctl_pkg::cmd_type cmd;

   // sequencer: accept, compare cycle, update cycle, result strobe
   fctl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .csr_valid (csr_valid),
      .busy      (busy),
      .csr_ready (csr_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // line store, comparators, replacement and counters
   fctl_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

   // compare cycle lasts exactly one cycle
   a_busy_one: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held longer than one cycle");

   // every accepted word is followed by the busy compare cycle and then by its result strobe
   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy ##2 rsp_valid)
      else $error("result strobe missing after accept");

   // no two result strobes come back to back
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");

   // no config write during the compare cycle
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !busy)
      else $error("config port open during an access");

endmodule
